// ===== rtl/core/morse_timing_encoder_top_assert.svh =====
// Assertion macros for the Morse timing encoder.
`ifndef MORSE_TIMING_ENCODER_TOP_ASSERT_SVH
`define MORSE_TIMING_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define MTE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define MTE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mte_pkg.sv =====
package mte_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned DitW   = 10;
  localparam int unsigned CapW   = 11;
  localparam int unsigned DurW   = 13;
  localparam int unsigned UnitW  = 3;
  localparam int unsigned CntW   = 3;
  localparam int unsigned ElemW  = 2;
  localparam int unsigned StepW  = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [DitW-1:0] DitReset = DitW'(128);
  localparam logic [CapW-1:0] CapReset = CapW'(64);

  localparam logic [CharW-1:0] CharSpace   = CharW'(32);
  localparam logic [CharW-1:0] CharUpperA  = CharW'(65);
  localparam logic [CharW-1:0] CharUpperZ  = CharW'(90);
  localparam logic [CharW-1:0] CharLowerA  = CharW'(97);
  localparam logic [CharW-1:0] CharLowerZ  = CharW'(122);

  localparam logic [UnitW-1:0] UnitDot       = UnitW'(1);
  localparam logic [UnitW-1:0] UnitDah       = UnitW'(3);
  localparam logic [UnitW-1:0] UnitLetterGap = UnitW'(3);
  localparam logic [UnitW-1:0] UnitWordGap   = UnitW'(7);

  localparam logic [CfgIdxW-1:0] RegDitLength = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegCapacity  = CfgIdxW'(1);

  typedef logic [StepW-1:0] step_t;

  localparam step_t StepWait  = StepW'(0);
  localparam step_t StepPgap  = StepW'(1);
  localparam step_t StepMark  = StepW'(2);
  localparam step_t StepEgap  = StepW'(3);
  localparam step_t StepClose = StepW'(4);

  typedef enum logic [2:0] {
    C_ACCEPT = 3'd0,
    C_GAP    = 3'd1,
    C_LETTER = 3'd2,
    C_MORE   = 3'd3,
    C_CLOSE  = 3'd4
  } cond_e;

  typedef enum logic [2:0] {
    E_NONE  = 3'd0,
    E_PGAP  = 3'd1,
    E_MARK  = 3'd2,
    E_EGAP  = 3'd3,
    E_CLOSE = 3'd4
  } emit_e;

  typedef struct packed {
    cond_e cond;
    emit_e emit;
    step_t nxt_t;
    step_t nxt_f;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic out_full;
    logic has_gap;
    logic has_letter;
    logic more;
    logic close;
  } seq_stat_t;

  typedef struct packed {
    logic  ready;
    emit_e emit;
  } seq_ctrl_t;

  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic [3:0]      dah;
  } morse_t;

  function automatic ucode_t ucode_rom(step_t step);
    ucode_t w;
    unique case (step)
      StepWait:  w = '{C_ACCEPT, E_NONE,  StepPgap, StepWait};
      StepPgap:  w = '{C_GAP,    E_PGAP,  StepMark, StepMark};
      StepMark:  w = '{C_LETTER, E_MARK,  StepEgap, StepClose};
      StepEgap:  w = '{C_MORE,   E_EGAP,  StepMark, StepClose};
      StepClose: w = '{C_CLOSE,  E_CLOSE, StepWait, StepWait};
      default:   w = '{C_ACCEPT, E_NONE,  StepWait, StepWait};
    endcase
    return w;
  endfunction

  // dah bit i marks element i as a dah
  function automatic morse_t morse_lookup(logic [4:0] idx);
    morse_t m;
    unique case (idx)
      5'd0:    m = '{3'd2, 4'b0010};
      5'd1:    m = '{3'd4, 4'b0001};
      5'd2:    m = '{3'd4, 4'b0101};
      5'd3:    m = '{3'd3, 4'b0001};
      5'd4:    m = '{3'd1, 4'b0000};
      5'd5:    m = '{3'd4, 4'b0100};
      5'd6:    m = '{3'd3, 4'b0011};
      5'd7:    m = '{3'd4, 4'b0000};
      5'd8:    m = '{3'd2, 4'b0000};
      5'd9:    m = '{3'd4, 4'b1110};
      5'd10:   m = '{3'd3, 4'b0101};
      5'd11:   m = '{3'd4, 4'b0010};
      5'd12:   m = '{3'd2, 4'b0011};
      5'd13:   m = '{3'd2, 4'b0001};
      5'd14:   m = '{3'd3, 4'b0111};
      5'd15:   m = '{3'd4, 4'b0110};
      5'd16:   m = '{3'd4, 4'b1011};
      5'd17:   m = '{3'd3, 4'b0010};
      5'd18:   m = '{3'd3, 4'b0000};
      5'd19:   m = '{3'd1, 4'b0001};
      5'd20:   m = '{3'd3, 4'b0100};
      5'd21:   m = '{3'd4, 4'b1000};
      5'd22:   m = '{3'd3, 4'b0110};
      5'd23:   m = '{3'd4, 4'b1001};
      5'd24:   m = '{3'd4, 4'b1101};
      5'd25:   m = '{3'd4, 4'b0011};
      default: m = '{3'd0, 4'b0000};
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/mte_stream_if.sv =====
interface mte_in_if;
  import mte_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             end_of_message;

  modport source (output valid, char_code, end_of_message, input ready);
  modport sink (input valid, char_code, end_of_message, output ready);
endinterface

interface mte_out_if;
  import mte_pkg::*;
  logic            valid;
  logic            ready;
  logic            signal_on;
  logic [DurW-1:0] duration;
  logic            last_of_run;
  logic            message_done;

  modport source (output valid, signal_on, duration, last_of_run, message_done, input ready);
  modport sink (input valid, signal_on, duration, last_of_run, message_done, output ready);
endinterface

// ===== rtl/core/mte_seq.sv =====
module mte_seq
  import mte_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  seq_stat_t stat_i,
  output seq_ctrl_t ctrl_o
);

  step_t  step_q, step_d;
  ucode_t word;
  logic   cond_ok;
  logic   fire;
  logic   stall;

  assign word = ucode_rom(step_q);

  always_comb begin
    unique case (word.cond)
      C_ACCEPT: cond_ok = stat_i.in_valid;
      C_GAP:    cond_ok = stat_i.has_gap;
      C_LETTER: cond_ok = stat_i.has_letter;
      C_MORE:   cond_ok = stat_i.more;
      C_CLOSE:  cond_ok = stat_i.close;
      default:  cond_ok = 1'b0;
    endcase
  end

  assign fire  = cond_ok && (word.emit != E_NONE);
  assign stall = fire && stat_i.out_full;

  always_comb begin
    if (stall) begin
      step_d = step_q;
    end else if (cond_ok) begin
      step_d = word.nxt_t;
    end else begin
      step_d = word.nxt_f;
    end
  end

  assign ctrl_o.ready = (step_q == StepWait);
  assign ctrl_o.emit  = (fire && !stall) ? word.emit : E_NONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepWait;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== rtl/core/mte_dpath.sv =====
module mte_dpath
  import mte_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CapW-1:0]    cfg_data_i,
  input  seq_ctrl_t          ctrl_i,
  output seq_stat_t          stat_o,
  mte_in_if.sink             in_i,
  mte_out_if.source          out_o
);

  `include "morse_timing_encoder_top_assert.svh"

  logic [DitW-1:0] dit_q;
  logic [CapW-1:0] cap_q;

  logic            gap_pending_q, gap_pending_d;
  logic            pend_word_q, pend_word_d;
  logic [CapW-1:0] count_q, count_d;
  logic            hit_q, hit_d;

  logic             has_gap_q, has_letter_q, close_q, gap_word_q;
  logic [CntW-1:0]  cnt_q;
  logic [3:0]       dah_q;
  logic [ElemW-1:0] idx_q;

  logic             out_valid_q;
  logic             out_on_q, out_last_q, out_done_q;
  logic [DurW-1:0]  out_dur_q;

  logic             accept;
  logic             is_upper, is_lower, is_letter, is_space;
  logic [CharW-1:0] off;
  morse_t           info;
  logic [CapW:0]    sum;
  logic             fits, letter_go, gp_after;
  logic             more;
  logic [UnitW-1:0] units;
  logic             on_n, last_n, done_n;

  assign accept = in_i.valid && ctrl_i.ready;
  assign in_i.ready = ctrl_i.ready;

  assign is_upper  = (in_i.char_code >= CharUpperA) && (in_i.char_code <= CharUpperZ);
  assign is_lower  = (in_i.char_code >= CharLowerA) && (in_i.char_code <= CharLowerZ);
  assign is_letter = is_upper || is_lower;
  assign is_space  = (in_i.char_code == CharSpace);
  assign off       = in_i.char_code - (is_upper ? CharUpperA : CharLowerA);
  assign info      = morse_lookup(off[4:0]);

  assign sum       = {1'b0, count_q} + (CapW+1)'({info.cnt, 1'b0});
  assign fits      = sum <= {1'b0, cap_q};
  assign letter_go = !hit_q && is_letter && fits;
  assign gp_after  = gap_pending_q || letter_go;

  always_comb begin
    gap_pending_d = gap_pending_q;
    pend_word_d   = pend_word_q;
    count_d       = count_q;
    hit_d         = hit_q;
    if (in_i.end_of_message) begin
      gap_pending_d = 1'b0;
      pend_word_d   = 1'b0;
      count_d       = '0;
      hit_d         = 1'b0;
    end else if (!hit_q) begin
      if (is_space) begin
        pend_word_d = pend_word_q || gap_pending_q;
      end else if (letter_go) begin
        gap_pending_d = 1'b1;
        pend_word_d   = 1'b0;
        count_d       = sum[CapW-1:0];
      end else if (is_letter) begin
        hit_d = 1'b1;
      end
    end
  end

  assign more = ({1'b0, idx_q} + CntW'(1)) < cnt_q;

  assign stat_o.in_valid   = in_i.valid;
  assign stat_o.out_full   = out_valid_q && !out_o.ready;
  assign stat_o.has_gap    = has_gap_q;
  assign stat_o.has_letter = has_letter_q;
  assign stat_o.more       = more;
  assign stat_o.close      = close_q;

  always_comb begin
    units  = UnitDot;
    on_n   = 1'b0;
    last_n = 1'b0;
    done_n = 1'b0;
    unique case (ctrl_i.emit)
      E_PGAP: begin
        units  = gap_word_q ? UnitWordGap : UnitLetterGap;
        last_n = !has_letter_q && !close_q;
      end
      E_MARK: begin
        units  = dah_q[idx_q] ? UnitDah : UnitDot;
        on_n   = 1'b1;
        last_n = !more && !close_q;
      end
      E_EGAP: begin
        units = UnitDot;
      end
      E_CLOSE: begin
        units  = UnitWordGap;
        last_n = 1'b1;
        done_n = 1'b1;
      end
      default: begin
        units = UnitDot;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dit_q         <= DitReset;
      cap_q         <= CapReset;
      gap_pending_q <= 1'b0;
      pend_word_q   <= 1'b0;
      count_q       <= '0;
      hit_q         <= 1'b0;
      has_gap_q     <= 1'b0;
      has_letter_q  <= 1'b0;
      close_q       <= 1'b0;
      cnt_q         <= '0;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegDitLength: dit_q <= cfg_data_i[DitW-1:0];
          RegCapacity:  cap_q <= cfg_data_i;
          default:      cap_q <= cap_q;
        endcase
      end
      if (accept) begin
        gap_pending_q <= gap_pending_d;
        pend_word_q   <= pend_word_d;
        count_q       <= count_d;
        hit_q         <= hit_d;
        has_gap_q     <= letter_go && gap_pending_q;
        has_letter_q  <= letter_go;
        close_q       <= in_i.end_of_message && gp_after;
        cnt_q         <= info.cnt;
        idx_q         <= '0;
      end else if (ctrl_i.emit == E_EGAP) begin
        idx_q <= idx_q + ElemW'(1);
      end
      if (ctrl_i.emit != E_NONE) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      gap_word_q <= pend_word_q;
      dah_q      <= info.dah;
    end
    if (ctrl_i.emit != E_NONE) begin
      out_on_q   <= on_n;
      out_last_q <= last_n;
      out_done_q <= done_n;
      out_dur_q  <= DurW'({{(DurW-DitW){1'b0}}, dit_q} * {{(DurW-UnitW){1'b0}}, units});
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.signal_on    = out_on_q;
  assign out_o.duration     = out_dur_q;
  assign out_o.last_of_run  = out_last_q;
  assign out_o.message_done = out_done_q;

  `MTE_ASSERT_IMP(a_no_overwrite, ctrl_i.emit != E_NONE, !(out_valid_q && !out_o.ready),
                  "result register overwritten while a beat waits")
  `MTE_ASSERT_NXT(a_close_flags, ctrl_i.emit == E_CLOSE,
                  out_valid_q && out_done_q && out_last_q,
                  "closing gap lacks done or last flag")
  `MTE_ASSERT_IMP(a_elem_range, has_letter_q && (cnt_q != '0), {1'b0, idx_q} < cnt_q,
                  "element index beyond letter length")

endmodule

// ===== rtl/core/morse_timing_encoder_top.sv =====
// Channel | Dir | Beat payload
// --------+-----+----------------------------------------------------
// in_i    | in  | char_code[7:0], end_of_message
// out_o   | out | signal_on, duration[12:0], last_of_run, message_done
// cfg     | in  | cfg_we_i, cfg_idx_i (0 dit_length, 1 capacity), cfg_data_i[10:0]
//
// An item is taken only in the wait step of the control program; the program then steps
// through pending gap, then mark and inner gap per element, then close.
// A full result register holds the program on its current step until the beat leaves.
// Reset restores dit_length 128, capacity 64 and clears all message state.
module morse_timing_encoder_top
  import mte_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CapW-1:0]    cfg_data_i,
  mte_in_if.sink             in_i,
  mte_out_if.source          out_o
);

  seq_stat_t stat;
  seq_ctrl_t ctrl;

  mte_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  mte_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .in_i       (in_i),
    .out_o      (out_o)
  );

endmodule

// ===== dv/tb_morse_timing_encoder_top.sv =====
module tb_morse_timing_encoder_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mte_pkg::*;

  typedef struct packed {
    logic            mark;
    logic [DurW-1:0] dur;
    logic            last;
    logic            done;
  } beat_t;

  typedef struct packed {
    logic               is_cfg;
    logic [CfgIdxW-1:0] reg_idx;
    logic [CapW-1:0]    reg_val;
    logic [CharW-1:0]   ch;
    logic               eom;
    int                 n_typed;
    beat_t [0:2]        typed;
  } row_t;

  localparam int Predict     = -1;
  localparam int DrainCycles = 24;
  localparam int NumPhases   = 8;
  localparam int PhaseItems  = 56;
  localparam int HoldCycles  = 400;

  localparam beat_t NoBeat   = '0;
  localparam beat_t DitLast  = '{1'b1, 13'd128, 1'b1, 1'b0};
  localparam beat_t DitMark  = '{1'b1, 13'd128, 1'b0, 1'b0};
  localparam beat_t DahMark  = '{1'b1, 13'd384, 1'b0, 1'b0};
  localparam beat_t LetGap   = '{1'b0, 13'd384, 1'b0, 1'b0};
  localparam beat_t CloseGap = '{1'b0, 13'd896, 1'b1, 1'b1};

  logic clk_i;
  logic rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CapW-1:0]    cfg_data_i;

  mte_in_if  in_if ();
  mte_out_if out_if ();

  morse_timing_encoder_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // encoder state mirror
  logic [DitW-1:0] dit_len;
  logic [CapW-1:0] cap_len;
  logic            gap_pend;
  logic            word_pend;
  logic [CapW-1:0] entries;
  logic            cap_hit;

  beat_t step_beats [$];
  beat_t expected_beats [$];
  beat_t head_beat;
  int    err_count;
  int    beats_rx;
  int    rx_cyc;
  int    rx_mode;
  bit    hold_done;
  int    msg_left;
  int    sent;
  int    burst;
  int    gap;
  int    pick;
  row_t  rnd_row;

  row_t dir_rows [$] = '{
    '{1'b0, RegDitLength, 11'd0, "E", 1'b0, 1, {DitLast, NoBeat, NoBeat}},
    '{1'b0, RegDitLength, 11'd0, "e", 1'b1, 3, {LetGap, DitMark, CloseGap}},
    '{1'b0, RegDitLength, 11'd0, " ", 1'b1, 0, {NoBeat, NoBeat, NoBeat}},
    '{1'b0, RegDitLength, 11'd0, 8'hFF, 1'b1, 0, {NoBeat, NoBeat, NoBeat}},
    '{1'b0, RegDitLength, 11'd0, "T", 1'b1, 2, {DahMark, CloseGap, NoBeat}},
    '{1'b0, RegDitLength, 11'd0, "A", 1'b0, Predict, '0},
    '{1'b0, RegDitLength, 11'd0, " ", 1'b0, Predict, '0},
    '{1'b0, RegDitLength, 11'd0, "z", 1'b0, Predict, '0},
    '{1'b0, RegDitLength, 11'd0, 8'h00, 1'b0, Predict, '0},
    '{1'b0, RegDitLength, 11'd0, "Z", 1'b0, Predict, '0},
    '{1'b0, RegDitLength, 11'd0, 8'h80, 1'b0, Predict, '0},
    '{1'b0, RegDitLength, 11'd0, 8'h40, 1'b0, Predict, '0},
    '{1'b0, RegDitLength, 11'd0, 8'h5B, 1'b0, Predict, '0},
    '{1'b0, RegDitLength, 11'd0, 8'h60, 1'b0, Predict, '0},
    '{1'b0, RegDitLength, 11'd0, 8'h7B, 1'b0, Predict, '0},
    '{1'b0, RegDitLength, 11'd0, "Q", 1'b1, Predict, '0},
    '{1'b1, RegCapacity, 11'd2, 8'h00, 1'b0, Predict, '0},
    '{1'b0, RegDitLength, 11'd0, "E", 1'b0, Predict, '0},
    '{1'b0, RegDitLength, 11'd0, "A", 1'b0, Predict, '0},
    '{1'b0, RegDitLength, 11'd0, " ", 1'b0, Predict, '0},
    '{1'b0, RegDitLength, 11'd0, "T", 1'b1, Predict, '0},
    '{1'b1, RegCapacity, 11'd1, 8'h00, 1'b0, Predict, '0},
    '{1'b0, RegDitLength, 11'd0, "E", 1'b1, Predict, '0},
    '{1'b1, RegDitLength, 11'd0, 8'h00, 1'b0, Predict, '0},
    '{1'b1, RegCapacity, 11'd1024, 8'h00, 1'b0, Predict, '0},
    '{1'b0, RegDitLength, 11'd0, "M", 1'b0, Predict, '0},
    '{1'b0, RegDitLength, 11'd0, "K", 1'b1, Predict, '0},
    '{1'b1, RegDitLength, 11'h7FF, 8'h00, 1'b0, Predict, '0},
    '{1'b0, RegDitLength, 11'd0, "Y", 1'b1, Predict, '0}
  };

  function automatic string morse_code(logic [CharW-1:0] ch);
    int idx;
    idx = -1;
    if (ch >= CharUpperA && ch <= CharUpperZ) idx = int'(ch - CharUpperA);
    else if (ch >= CharLowerA && ch <= CharLowerZ) idx = int'(ch - CharLowerA);
    case (idx)
      0:  return ".-";
      1:  return "-...";
      2:  return "-.-.";
      3:  return "-..";
      4:  return ".";
      5:  return "..-.";
      6:  return "--.";
      7:  return "....";
      8:  return "..";
      9:  return ".---";
      10: return "-.-";
      11: return ".-..";
      12: return "--";
      13: return "-.";
      14: return "---";
      15: return ".--.";
      16: return "--.-";
      17: return ".-.";
      18: return "...";
      19: return "-";
      20: return "..-";
      21: return "...-";
      22: return ".--";
      23: return "-..-";
      24: return "-.--";
      25: return "--..";
      default: return "";
    endcase
  endfunction

  function automatic void add_beat(logic mark, int unsigned units, logic done);
    beat_t b;
    b.mark = mark;
    b.dur  = DurW'(units * int'(dit_len));
    b.last = 1'b0;
    b.done = done;
    step_beats.push_back(b);
  endfunction

  task automatic encode_char(input logic [CharW-1:0] ch, input logic eom);
    string code;
    int    len;
    step_beats.delete();
    if (!cap_hit) begin
      if (ch == CharSpace) begin
        if (gap_pend) word_pend = 1'b1;
      end else begin
        code = morse_code(ch);
        len  = code.len();
        if (len != 0) begin
          if (int'(entries) + 2 * len > int'(cap_len)) begin
            cap_hit = 1'b1;
          end else begin
            if (gap_pend) add_beat(1'b0, word_pend ? 7 : 3, 1'b0);
            for (int i = 0; i < len; i++) begin
              add_beat(1'b1, (code[i] == "-") ? 3 : 1, 1'b0);
              if (i + 1 < len) add_beat(1'b0, 1, 1'b0);
            end
            gap_pend  = 1'b1;
            word_pend = 1'b0;
            entries   = entries + CapW'(2 * len);
          end
        end
      end
    end
    if (eom) begin
      if (gap_pend) add_beat(1'b0, 7, 1'b1);
      gap_pend  = 1'b0;
      word_pend = 1'b0;
      entries   = '0;
      cap_hit   = 1'b0;
    end
    if (step_beats.size() != 0) step_beats[step_beats.size() - 1].last = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, exp_val);
    err_count++;
  endtask

  task automatic send_char(input row_t r);
    @(negedge clk_i);
    in_if.valid          = 1'b1;
    in_if.char_code      = r.ch;
    in_if.end_of_message = r.eom;
    do @(posedge clk_i); while (!in_if.ready);
    encode_char(r.ch, r.eom);
    if (r.n_typed >= 0) begin
      for (int i = 0; i < r.n_typed; i++) expected_beats.push_back(r.typed[i]);
    end else begin
      foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
    end
  endtask

  task automatic pause(input int cycles);
    @(negedge clk_i);
    in_if.valid = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // drop valid, drain every expected beat, then let the control program settle
  task automatic settle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CapW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    if (idx == RegDitLength) dit_len = data[DitW-1:0];
    else cap_len = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      beats_rx++;
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat duration", int'(out_if.duration), 0);
      end else begin
        head_beat = expected_beats.pop_front();
        if (out_if.signal_on !== head_beat.mark)
          report_mismatch("signal_on", int'(out_if.signal_on), int'(head_beat.mark));
        if (out_if.duration !== head_beat.dur)
          report_mismatch("duration", int'(out_if.duration), int'(head_beat.dur));
        if (out_if.last_of_run !== head_beat.last)
          report_mismatch("last_of_run", int'(out_if.last_of_run), int'(head_beat.last));
        if (out_if.message_done !== head_beat.done)
          report_mismatch("message_done", int'(out_if.message_done), int'(head_beat.done));
      end
    end
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rx_cyc++;
      if (rx_cyc % 50 == 0) rx_mode = $urandom_range(0, 2);
      if (!hold_done && beats_rx >= 150) begin
        hold_done    = 1'b1;
        out_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      case (rx_mode)
        0:       out_if.ready = 1'b1;
        1:       out_if.ready = 1'($urandom_range(0, 1));
        default: out_if.ready = (rx_cyc % 4 == 0);
      endcase
    end
  end

  initial begin
    in_if.valid          = 1'b0;
    in_if.char_code      = '0;
    in_if.end_of_message = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = RegDitLength;
    cfg_data_i = '0;
    dit_len    = DitReset;
    cap_len    = CapReset;
    gap_pend   = 1'b0;
    word_pend  = 1'b0;
    entries    = '0;
    cap_hit    = 1'b0;
    err_count  = 0;
    beats_rx   = 0;
    rx_cyc     = 0;
    rx_mode    = 0;
    hold_done  = 1'b0;
    msg_left   = 0;
    rst_ni     = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_char(dir_rows[i]);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(RegDitLength, 11'd1023);
          write_reg(RegCapacity, 11'd1024);
        end
        1: begin
          write_reg(RegDitLength, 11'd1);
          write_reg(RegCapacity, 11'd2);
        end
        2: begin
          write_reg(RegDitLength, 11'd0);
          write_reg(RegCapacity, 11'd1);
        end
        3: begin
          write_reg(RegDitLength, 11'd128);
          write_reg(RegCapacity, 11'd64);
        end
        default: begin
          write_reg(RegDitLength, CapW'($urandom_range(0, 2047)));
          write_reg(RegCapacity, CapW'($urandom_range(0, 2047)));
        end
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        burst = $urandom_range(1, 16);
        if (burst > PhaseItems - sent) burst = PhaseItems - sent;
        repeat (burst) begin
          if (msg_left == 0)
            msg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 10);
          pick = $urandom_range(0, 99);
          if (pick < 65)
            rnd_row.ch = ($urandom_range(0, 1) ? CharUpperA : CharLowerA)
                         + CharW'($urandom_range(0, 25));
          else if (pick < 82)
            rnd_row.ch = CharSpace;
          else
            rnd_row.ch = CharW'($urandom_range(0, 255));
          msg_left--;
          rnd_row.eom = (msg_left == 0) || ($urandom_range(0, 49) == 0);
          if (rnd_row.eom) msg_left = 0;
          rnd_row.is_cfg  = 1'b0;
          rnd_row.n_typed = Predict;
          send_char(rnd_row);
          sent++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) pause(gap);
      end
    end

    settle();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
